/* hdl/snfce_pkg.sv */
`timescale 1ns / 1ps
// types, codes and result helpers for the serial nor flash command engine
// no dependencies; imported by every module of the engine

package snfce_pkg;

  // most result items that one input item can cause, and the count width
  localparam int unsigned MAX_RES = 8;
  localparam int unsigned CNT_W   = 4;

  // spi flash command bytes
  localparam logic [7:0] CMD_READ_ID = 8'h9F;
  localparam logic [7:0] CMD_WREN    = 8'h06;
  localparam logic [7:0] CMD_RDSR    = 8'h05;
  localparam logic [7:0] CMD_SE      = 8'h20;
  localparam logic [7:0] CMD_PP      = 8'h02;
  localparam logic [7:0] CMD_READ    = 8'h03;
  localparam logic [7:0] CMD_RES     = 8'hAB;
  localparam logic [7:0] FILL_BYTE   = 8'hFF;

  // status register busy flag position
  localparam int unsigned STATUS_BUSY_BIT = 0;

  // host request codes
  typedef enum logic [2:0] {
    OP_READ_ID    = 3'd0,
    OP_ERASE      = 3'd1,
    OP_PROG_BEGIN = 3'd2,
    OP_PROG_DATA  = 3'd3,
    OP_READ_BEGIN = 3'd4,
    OP_WAKEUP     = 3'd5,
    OP_LINK_REPLY = 3'd6
  } op_e;

  // engine modes
  typedef enum logic [2:0] {
    MODE_IDLE       = 3'd0,
    MODE_ID         = 3'd1,
    MODE_ERASE_POLL = 3'd2,
    MODE_PROG_DATA  = 3'd3,
    MODE_PROG_POLL  = 3'd4,
    MODE_READ       = 3'd5
  } mode_e;

  // input item
  typedef struct packed {
    logic [2:0]  operation;
    logic [23:0] flash_address;
    logic [15:0] byte_count;
    logic [7:0]  data_byte;
    logic [7:0]  miso_byte;
  } in_t;

  // result item
  typedef struct packed {
    logic [7:0]  mosi_byte;
    logic        mosi_valid;
    logic        frame_end;
    logic        expect_reply;
    logic [7:0]  read_data;
    logic        read_valid;
    logic [23:0] flash_id;
    logic        id_valid;
    logic        op_done;
    logic        last;
  } res_t;

  // engine state that does not depend on the page size
  typedef struct packed {
    mode_e       mode;
    logic [23:0] cur_addr;
    logic [15:0] rem;
    logic [23:0] id_shift;
    logic [1:0]  id_idx;
  } st_t;

  // byte transfer toward the flash
  function automatic res_t f_send(logic [7:0] b, logic fe, logic er);
    res_t r;
    r              = '0;
    r.mosi_byte    = b;
    r.mosi_valid   = 1'b1;
    r.frame_end    = fe;
    r.expect_reply = er;
    return r;
  endfunction

  // chip select release without a transfer
  function automatic res_t f_close(logic done);
    res_t r;
    r           = '0;
    r.frame_end = 1'b1;
    r.op_done   = done;
    return r;
  endfunction

endpackage

/* hdl/snfce_decode.sv */
`timescale 1ns / 1ps
// next state and result burst for one input item
// depends on snfce_pkg

module snfce_decode #(
  parameter int unsigned PAGE_BYTES = 256
) (
  input  snfce_pkg::in_t                            item_i,
  input  snfce_pkg::st_t                            st_i,
  input  logic [$clog2(PAGE_BYTES):0]               room_i,
  output snfce_pkg::st_t                            st_o,
  output logic [$clog2(PAGE_BYTES):0]               room_o,
  output snfce_pkg::res_t [snfce_pkg::MAX_RES-1:0]  burst_o,
  output logic [snfce_pkg::CNT_W-1:0]               cnt_o
);
  import snfce_pkg::*;

  localparam int unsigned OW = $clog2(PAGE_BYTES);
  localparam int unsigned RW = OW + 1;

  logic          idle;
  logic [RW-1:0] room_in_addr;
  logic [RW-1:0] room_cur_addr;
  logic [15:0]   rem_dec;
  logic [RW-1:0] room_dec;
  logic [23:0]   addr_inc;
  logic [23:0]   id_next;
  logic          busy;

  // helpers; mask offset: user keeps page size a power of two, unchecked
  assign idle          = (st_i.mode == MODE_IDLE);
  assign room_in_addr  = RW'(PAGE_BYTES) - {1'b0, item_i.flash_address[OW-1:0]};
  assign room_cur_addr = RW'(PAGE_BYTES) - {1'b0, st_i.cur_addr[OW-1:0]};
  assign rem_dec       = (st_i.rem != '0) ? st_i.rem - 16'd1 : st_i.rem;
  assign room_dec      = room_i - RW'(1);
  assign addr_inc      = st_i.cur_addr + 24'd1;
  assign id_next       = {st_i.id_shift[15:0], item_i.miso_byte};
  assign busy          = item_i.miso_byte[STATUS_BUSY_BIT];

  // request and reply handling
  always_comb begin
    st_o    = st_i;
    room_o  = room_i;
    burst_o = '0;
    cnt_o   = '0;
    unique case (op_e'(item_i.operation))
      OP_READ_ID: begin
        if (idle) begin
          st_o.id_shift = '0;
          st_o.id_idx   = '0;
          st_o.mode     = MODE_ID;
          burst_o[0]    = f_send(CMD_READ_ID, 1'b0, 1'b0);
          burst_o[1]    = f_send(FILL_BYTE, 1'b0, 1'b1);
          cnt_o         = CNT_W'(2);
        end
      end
      OP_ERASE: begin
        if (idle) begin
          st_o.mode  = MODE_ERASE_POLL;
          burst_o[0] = f_send(CMD_WREN, 1'b1, 1'b0);
          burst_o[1] = f_send(CMD_WREN, 1'b1, 1'b0);
          burst_o[2] = f_send(CMD_SE, 1'b0, 1'b0);
          burst_o[3] = f_send(item_i.flash_address[23:16], 1'b0, 1'b0);
          burst_o[4] = f_send(item_i.flash_address[15:8], 1'b0, 1'b0);
          burst_o[5] = f_send(item_i.flash_address[7:0], 1'b1, 1'b0);
          burst_o[6] = f_send(CMD_RDSR, 1'b0, 1'b0);
          burst_o[7] = f_send(FILL_BYTE, 1'b0, 1'b1);
          cnt_o      = CNT_W'(8);
        end
      end
      OP_PROG_BEGIN: begin
        if (idle) begin
          if (item_i.byte_count == '0) begin
            burst_o[0]         = '0;
            burst_o[0].op_done = 1'b1;
            cnt_o              = CNT_W'(1);
          end else begin
            st_o.cur_addr = item_i.flash_address;
            st_o.rem      = item_i.byte_count;
            st_o.mode     = MODE_PROG_DATA;
            room_o        = room_in_addr;
            burst_o[0]    = f_send(CMD_WREN, 1'b1, 1'b0);
            burst_o[1]    = f_send(CMD_PP, 1'b0, 1'b0);
            burst_o[2]    = f_send(item_i.flash_address[23:16], 1'b0, 1'b0);
            burst_o[3]    = f_send(item_i.flash_address[15:8], 1'b0, 1'b0);
            burst_o[4]    = f_send(item_i.flash_address[7:0], 1'b0, 1'b0);
            cnt_o         = CNT_W'(5);
          end
        end
      end
      OP_PROG_DATA: begin
        if (st_i.mode == MODE_PROG_DATA) begin
          st_o.rem      = st_i.rem - 16'd1;
          st_o.cur_addr = addr_inc;
          room_o        = room_dec;
          if (st_i.rem == 16'd1 || room_dec == '0) begin
            st_o.mode  = MODE_PROG_POLL;
            burst_o[0] = f_send(item_i.data_byte, 1'b1, 1'b0);
            burst_o[1] = f_send(CMD_RDSR, 1'b0, 1'b0);
            burst_o[2] = f_send(FILL_BYTE, 1'b0, 1'b1);
            cnt_o      = CNT_W'(3);
          end else begin
            burst_o[0] = f_send(item_i.data_byte, 1'b0, 1'b0);
            cnt_o      = CNT_W'(1);
          end
        end
      end
      OP_READ_BEGIN: begin
        if (idle) begin
          st_o.cur_addr = item_i.flash_address;
          st_o.rem      = item_i.byte_count;
          burst_o[0]    = f_send(CMD_READ, 1'b0, 1'b0);
          burst_o[1]    = f_send(item_i.flash_address[23:16], 1'b0, 1'b0);
          burst_o[2]    = f_send(item_i.flash_address[15:8], 1'b0, 1'b0);
          if (item_i.byte_count == '0) begin
            burst_o[3]         = f_send(item_i.flash_address[7:0], 1'b1, 1'b0);
            burst_o[3].op_done = 1'b1;
            cnt_o              = CNT_W'(4);
          end else begin
            st_o.mode  = MODE_READ;
            burst_o[3] = f_send(item_i.flash_address[7:0], 1'b0, 1'b0);
            burst_o[4] = f_send(FILL_BYTE, item_i.byte_count == 16'd1, 1'b1);
            cnt_o      = CNT_W'(5);
          end
        end
      end
      OP_WAKEUP: begin
        if (idle) begin
          burst_o[0]         = f_send(CMD_RES, 1'b1, 1'b0);
          burst_o[0].op_done = 1'b1;
          cnt_o              = CNT_W'(1);
        end
      end
      OP_LINK_REPLY: begin
        unique case (st_i.mode)
          MODE_ID: begin
            st_o.id_shift = id_next;
            if (st_i.id_idx == 2'd0) begin
              st_o.id_idx = 2'd1;
              burst_o[0]  = f_send(FILL_BYTE, 1'b0, 1'b1);
            end else if (st_i.id_idx == 2'd1) begin
              st_o.id_idx = 2'd2;
              burst_o[0]  = f_send(FILL_BYTE, 1'b1, 1'b1);
            end else begin
              st_o.id_idx         = 2'd0;
              st_o.mode           = MODE_IDLE;
              burst_o[0]          = '0;
              burst_o[0].flash_id = id_next;
              burst_o[0].id_valid = 1'b1;
              burst_o[0].op_done  = 1'b1;
            end
            cnt_o = CNT_W'(1);
          end
          MODE_ERASE_POLL: begin
            if (busy) begin
              burst_o[0] = f_send(FILL_BYTE, 1'b0, 1'b1);
            end else begin
              st_o.mode  = MODE_IDLE;
              burst_o[0] = f_close(1'b1);
            end
            cnt_o = CNT_W'(1);
          end
          MODE_PROG_POLL: begin
            if (busy) begin
              burst_o[0] = f_send(FILL_BYTE, 1'b0, 1'b1);
              cnt_o      = CNT_W'(1);
            end else if (st_i.rem == '0) begin
              st_o.mode  = MODE_IDLE;
              burst_o[0] = f_close(1'b1);
              cnt_o      = CNT_W'(1);
            end else begin
              // next page frame
              st_o.mode  = MODE_PROG_DATA;
              room_o     = room_cur_addr;
              burst_o[0] = f_close(1'b0);
              burst_o[1] = f_send(CMD_WREN, 1'b1, 1'b0);
              burst_o[2] = f_send(CMD_PP, 1'b0, 1'b0);
              burst_o[3] = f_send(st_i.cur_addr[23:16], 1'b0, 1'b0);
              burst_o[4] = f_send(st_i.cur_addr[15:8], 1'b0, 1'b0);
              burst_o[5] = f_send(st_i.cur_addr[7:0], 1'b0, 1'b0);
              cnt_o      = CNT_W'(6);
            end
          end
          MODE_READ: begin
            st_o.rem             = rem_dec;
            burst_o[0]           = '0;
            burst_o[0].read_data = item_i.miso_byte;
            burst_o[0].read_valid = 1'b1;
            burst_o[0].op_done   = (rem_dec == '0);
            if (rem_dec == '0) begin
              st_o.mode = MODE_IDLE;
              cnt_o     = CNT_W'(1);
            end else begin
              burst_o[1] = f_send(FILL_BYTE, rem_dec == 16'd1, 1'b1);
              cnt_o      = CNT_W'(2);
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase

    // mark the final result of the burst
    for (int i = 0; i < MAX_RES; i++) begin
      burst_o[i].last = (cnt_o == CNT_W'(i + 1));
    end
  end

endmodule

/* hdl/snfce_burst.sv */
`timescale 1ns / 1ps
// result burst register, shifted out one item per cycle while the output is not stalled
// depends on snfce_pkg

module snfce_burst (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      load_i,
  input  snfce_pkg::res_t [snfce_pkg::MAX_RES-1:0]  burst_i,
  input  logic [snfce_pkg::CNT_W-1:0]               cnt_i,
  output logic                                      can_load_o,
  output logic                                      out_valid_o,
  input  logic                                      out_stall_i,
  output snfce_pkg::res_t                           out_item_o
);
  import snfce_pkg::*;

  res_t [MAX_RES-1:0] burst_q, burst_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               take;

  // output side
  assign out_valid_o = (cnt_q != '0);
  assign out_item_o  = burst_q[0];
  assign take        = out_valid_o && !out_stall_i;
  assign can_load_o  = (cnt_q == '0) || (cnt_q == CNT_W'(1) && take);

  // load a new burst or shift out the head item
  always_comb begin
    burst_d = burst_q;
    cnt_d   = cnt_q;
    if (load_i) begin
      burst_d = burst_i;
      cnt_d   = cnt_i;
    end else if (take) begin
      for (int i = 0; i < MAX_RES - 1; i++) begin
        burst_d[i] = burst_q[i + 1];
      end
      burst_d[MAX_RES-1] = '0;
      cnt_d              = cnt_q - CNT_W'(1);
    end
  end

  // count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // payload register
  always_ff @(posedge clk_i) begin
    burst_q <= burst_d;
  end

endmodule

/* hdl/serial_nor_flash_command_engine.sv */
`timescale 1ns / 1ps
// serial nor flash command engine: input register, state, decode, result burst
// first result is valid once the item moves from input register to burst register
// items: one per cycle while bursts are one result long and out_stall_i is low;
//   otherwise one per burst, since results shift out one per unstalled cycle
// reset: asynchronous active low; clears mode, address, counters and id state
// depends on snfce_pkg, snfce_decode, snfce_burst

module serial_nor_flash_command_engine #(
  parameter int unsigned PAGE_BYTES = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  snfce_pkg::in_t   in_item_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output snfce_pkg::res_t  out_item_o
);
  import snfce_pkg::*;

  localparam int unsigned RW = $clog2(PAGE_BYTES) + 1;

  in_t                item_q;
  logic               vld_q;
  st_t                st_q, st_d;
  logic [RW-1:0]      room_q, room_d;
  res_t [MAX_RES-1:0] burst;
  logic [CNT_W-1:0]   cnt;
  logic               can_load;
  logic               move;

  // item moves from the input register into the burst register
  assign move       = vld_q && can_load;
  assign in_stall_o = vld_q && !can_load;

  // input register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      vld_q <= 1'b1;
    end else if (move) begin
      vld_q <= 1'b0;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q <= in_item_i;
    end
  end

  // engine state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.mode     <= MODE_IDLE;
      st_q.cur_addr <= '0;
      st_q.rem      <= '0;
      st_q.id_shift <= '0;
      st_q.id_idx   <= '0;
      room_q        <= '0;
    end else if (move) begin
      st_q   <= st_d;
      room_q <= room_d;
    end
  end

  snfce_decode #(
    .PAGE_BYTES(PAGE_BYTES)
  ) u_decode (
    .item_i (item_q),
    .st_i   (st_q),
    .room_i (room_q),
    .st_o   (st_d),
    .room_o (room_d),
    .burst_o(burst),
    .cnt_o  (cnt)
  );

  snfce_burst u_burst (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (move),
    .burst_i    (burst),
    .cnt_i      (cnt),
    .can_load_o (can_load),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

endmodule
